/* rtl/bdpc_pkg.sv */
`default_nettype none

package bdpc_pkg;

    // fixed field widths
    localparam int RAW_WIDTH   = 4;
    localparam int INDEX_WIDTH = 2;
    localparam int CFG_WIDTH   = 16;
    localparam int CNT_WIDTH   = 17;

    // all ones marks an idle countdown
    localparam logic [CNT_WIDTH-1:0] CNT_IDLE = '1;

    // command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // register indexes
    localparam logic [1:0] CFG_LONG_TICKS   = 2'd0;
    localparam logic [1:0] CFG_DOUBLE_TICKS = 2'd1;
    localparam logic [1:0] CFG_PRESSED_LVL  = 2'd2;

    // register reset values
    localparam logic [CFG_WIDTH-1:0] LONG_TICKS_RESET   = 16'd100;
    localparam logic [CFG_WIDTH-1:0] DOUBLE_TICKS_RESET = 16'd50;
    localparam logic                 PRESSED_LVL_RESET  = 1'b0;
    localparam logic                 RELEASED_RESET     = ~PRESSED_LVL_RESET;

    typedef struct packed {
        logic                 pressed_level;
        logic [CFG_WIDTH-1:0] long_reload;
        logic [CFG_WIDTH-1:0] window_reload;
    } t_cfg;

    typedef struct packed {
        logic single_p;
        logic long_p;
        logic double_p;
        logic level_next;
    } t_lane_status;

    typedef struct packed {
        logic                 single_event;
        logic                 long_event;
        logic                 double_event;
        logic                 button_level;
        logic [RAW_WIDTH-1:0] all_levels;
    } t_result;

endpackage

`default_nettype wire

/* rtl/button_debounce_press_classifier.sv */
`default_nettype none

// Debouncer and press classifier for NUM_BUTTONS buttons. Each input word is
// either a tick (cmd 0), which shifts every button's raw level into a
// three-deep sample chain and updates its debounced level, press flags and
// countdowns, or a read (cmd 1), which returns the single, long and double
// press flags of button_index and clears them. Every word yields exactly one
// result word carrying the debounced level of button_index and of the first
// four buttons after the update. One button lane per button does the work in
// parallel and a merge stage picks the addressed lane, so a word is taken on
// every cycle unless input stall is high; its result is held in a two-word
// output buffer that decouples the sides: input stall rises only when both
// words are held by a stalled consumer. A duration register written as
// zero acts as one. Write configuration only while no word is in flight.
module button_debounce_press_classifier #(
    parameter int NUM_BUTTONS = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_cmd,
    input  wire  [3:0]  i_raw_levels,
    input  wire  [1:0]  i_button_index,
    // output channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_single_event,
    output logic        o_long_event,
    output logic        o_double_event,
    output logic        o_button_level,
    output logic [3:0]  o_all_levels,
    // configuration
    input  wire         i_cfg_wr_en,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_wdata
);

    // configuration registers
    logic [bdpc_pkg::CFG_WIDTH-1:0] r_long_ticks, r_double_ticks;
    logic                           r_pressed_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks    <= bdpc_pkg::LONG_TICKS_RESET;
            r_double_ticks  <= bdpc_pkg::DOUBLE_TICKS_RESET;
            r_pressed_level <= bdpc_pkg::PRESSED_LVL_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                bdpc_pkg::CFG_LONG_TICKS:   r_long_ticks    <= i_cfg_wdata;
                bdpc_pkg::CFG_DOUBLE_TICKS: r_double_ticks  <= i_cfg_wdata;
                bdpc_pkg::CFG_PRESSED_LVL:  r_pressed_level <= i_cfg_wdata[0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // zero durations count as one tick
    bdpc_pkg::t_cfg cfg;
    always_comb begin
        cfg.pressed_level = r_pressed_level;
        cfg.long_reload   = (r_long_ticks == '0) ? 16'd1 : r_long_ticks;
        cfg.window_reload = (r_double_ticks == '0) ? 16'd1 : r_double_ticks;
    end

    logic in_accept, out_pop;
    assign in_accept = i_in_valid && !o_in_stall;

    // button lanes
    bdpc_pkg::t_lane_status lane_status [NUM_BUTTONS];

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        logic raw_bit;
        if (g < bdpc_pkg::RAW_WIDTH) begin : g_raw
            assign raw_bit = i_raw_levels[g];
        end else begin : g_noraw
            // buttons past the raw field always sample low
            assign raw_bit = 1'b0;
        end

        bdpc_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tick   (in_accept && i_cmd == bdpc_pkg::CMD_TICK),
            .i_clear  (in_accept && i_cmd == bdpc_pkg::CMD_READ
                       && 32'(i_button_index) == g),
            .i_raw    (raw_bit),
            .i_cfg    (cfg),
            .o_status (lane_status[g])
        );
    end

    // pick the addressed lane and gather levels
    bdpc_pkg::t_result result;

    bdpc_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .i_cmd          (i_cmd),
        .i_button_index (i_button_index),
        .i_status       (lane_status),
        .o_result       (result)
    );

    // two-word output buffer
    bdpc_pkg::t_result r_buf [2];
    logic              r_wr_ptr, r_rd_ptr;
    logic [1:0]        r_count, n_count;

    assign out_pop     = o_out_valid && !i_out_stall;
    assign o_out_valid = (r_count != 2'd0);
    assign o_in_stall  = (r_count == 2'd2);

    always_comb begin
        n_count = r_count;
        if (in_accept && !out_pop) begin
            n_count = r_count + 2'd1;
        end else if (!in_accept && out_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (in_accept) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (out_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // hold payload until taken
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_buf[r_wr_ptr] <= result;
        end
    end

    assign o_single_event = r_buf[r_rd_ptr].single_event;
    assign o_long_event   = r_buf[r_rd_ptr].long_event;
    assign o_double_event = r_buf[r_rd_ptr].double_event;
    assign o_button_level = r_buf[r_rd_ptr].button_level;
    assign o_all_levels   = r_buf[r_rd_ptr].all_levels;

endmodule

`default_nettype wire

/* rtl/bdpc_lane.sv */
`default_nettype none

module bdpc_lane (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_tick,
    input  wire                   i_clear,
    input  wire                   i_raw,
    input  bdpc_pkg::t_cfg        i_cfg,
    output bdpc_pkg::t_lane_status o_status
);

    // The third sample of the chain is the middle sample of the previous tick,
    // so the stability check compares middle, newest and the incoming level.
    logic r_newest, r_middle, r_deb;
    logic n_newest, n_middle, n_deb;
    logic [bdpc_pkg::CNT_WIDTH-1:0] r_hold, n_hold, r_window, n_window;
    logic [bdpc_pkg::CNT_WIDTH-1:0] win_dec, hold_dec;
    logic r_first, n_first, r_single, n_single, r_long, n_long, r_double, n_double;

    always_comb begin
        n_newest = r_newest;
        n_middle = r_middle;
        n_deb    = r_deb;
        n_hold   = r_hold;
        n_window = r_window;
        n_first  = r_first;
        n_single = r_single;
        n_long   = r_long;
        n_double = r_double;
        win_dec  = r_window - 1'b1;
        hold_dec = r_hold - 1'b1;

        if (i_tick) begin
            n_middle = r_newest;
            n_newest = i_raw;

            // advance the double-press window
            if (r_window != bdpc_pkg::CNT_IDLE && r_window != '0) begin
                n_window = win_dec;
            end
            if (n_window == '0) begin
                n_first = 1'b0;
            end

            if (r_middle == r_newest && r_newest == i_raw) begin
                if (r_deb != i_raw) begin
                    n_deb = i_raw;
                    if (i_raw == i_cfg.pressed_level) begin
                        n_single = 1'b1;
                        n_hold   = {1'b0, i_cfg.long_reload};
                        if (!n_first) begin
                            n_first  = 1'b1;
                            n_window = {1'b0, i_cfg.window_reload};
                        end else begin
                            n_double = 1'b1;
                            n_first  = 1'b0;
                            n_window = bdpc_pkg::CNT_IDLE;
                        end
                    end else begin
                        n_hold = bdpc_pkg::CNT_IDLE;
                    end
                end else if (i_raw == i_cfg.pressed_level && r_hold != bdpc_pkg::CNT_IDLE) begin
                    if (hold_dec == '0) begin
                        n_hold = {1'b0, i_cfg.long_reload};
                        n_long = 1'b1;
                    end else begin
                        n_hold = hold_dec;
                    end
                end
            end
        end

        if (i_clear) begin
            n_single = 1'b0;
            n_long   = 1'b0;
            n_double = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= bdpc_pkg::RELEASED_RESET;
            r_middle <= bdpc_pkg::RELEASED_RESET;
            r_deb    <= bdpc_pkg::RELEASED_RESET;
            r_hold   <= bdpc_pkg::CNT_IDLE;
            r_window <= bdpc_pkg::CNT_IDLE;
            r_first  <= 1'b0;
            r_single <= 1'b0;
            r_long   <= 1'b0;
            r_double <= 1'b0;
        end else begin
            r_newest <= n_newest;
            r_middle <= n_middle;
            r_deb    <= n_deb;
            r_hold   <= n_hold;
            r_window <= n_window;
            r_first  <= n_first;
            r_single <= n_single;
            r_long   <= n_long;
            r_double <= n_double;
        end
    end

    assign o_status.single_p   = r_single;
    assign o_status.long_p     = r_long;
    assign o_status.double_p   = r_double;
    assign o_status.level_next = n_deb;

endmodule

`default_nettype wire

/* rtl/bdpc_merge.sv */
`default_nettype none

module bdpc_merge #(
    parameter int NUM_BUTTONS = 4
) (
    input  wire                                 i_cmd,
    input  wire  [bdpc_pkg::INDEX_WIDTH-1:0]    i_button_index,
    input  bdpc_pkg::t_lane_status              i_status [NUM_BUTTONS],
    output bdpc_pkg::t_result                   o_result
);

    always_comb begin
        o_result = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (i < bdpc_pkg::RAW_WIDTH) begin
                o_result.all_levels[i[bdpc_pkg::INDEX_WIDTH-1:0]] = i_status[i].level_next;
            end
            if (32'(i_button_index) == i) begin
                o_result.button_level = i_status[i].level_next;
                if (i_cmd == bdpc_pkg::CMD_READ) begin
                    o_result.single_event = i_status[i].single_p;
                    o_result.long_event   = i_status[i].long_p;
                    o_result.double_event = i_status[i].double_p;
                end
            end
        end
    end

endmodule

`default_nettype wire
